[rtl/slt_pkg.sv]
`default_nettype none

package slt_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  localparam int CMD_BITS    = 2;
  localparam int STATUS_BITS = 3;

  localparam int S_DATA_BITS = ((VALUE_BITS + IDX_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS = ((STATUS_BITS + IDX_BITS + COUNT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_CLEAR  = 2'd3
  } command_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_MISSING = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  // broadcast to every cell
  typedef struct packed {
    logic                  do_insert;
    logic                  do_delete;
    logic                  do_clear;
    logic [VALUE_BITS-1:0] value;
    logic [IDX_BITS-1:0]   position;
  } cell_ctrl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  valid;
    logic                  cond;
    logic                  eq;
  } cell_link_t;

  // first-hit markers reported to the top level
  typedef struct packed {
    logic first_cond;
    logic first_eq;
  } cell_hit_t;

endpackage

`default_nettype wire

[rtl/slt_cell.sv]
`default_nettype none

module slt_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire slt_pkg::cell_ctrl_t          ctrl,
  input  wire logic [slt_pkg::IDX_BITS-1:0] cell_index,
  input  wire slt_pkg::cell_link_t          left,
  input  wire slt_pkg::cell_link_t          right,
  output slt_pkg::cell_link_t               link,
  output slt_pkg::cell_hit_t                hit
);

  logic [slt_pkg::VALUE_BITS-1:0] value;
  logic [slt_pkg::VALUE_BITS-1:0] value_next;
  logic                           valid;
  logic                           valid_next;
  logic                           cond;
  logic                           eq;

  // empty cells count as greater than anything, so cond marks a suffix
  always_comb begin
    cond = !valid || ($signed(value) >= $signed(ctrl.value));
    eq   = valid && (value == ctrl.value);
  end

  always_comb begin
    link.value     = value;
    link.valid     = valid;
    link.cond      = cond;
    link.eq        = eq;
    hit.first_cond = cond && !left.cond;
    hit.first_eq   = eq && !left.eq;
  end

  always_comb begin
    value_next = value;
    valid_next = valid;
    priority if (ctrl.do_clear) begin
      valid_next = 1'b0;
    end else if (ctrl.do_insert && cond) begin
      if (left.cond) begin
        value_next = left.value;
        valid_next = left.valid;
      end else begin
        value_next = ctrl.value;
        valid_next = 1'b1;
      end
    end else if (ctrl.do_delete && (cell_index >= ctrl.position)) begin
      value_next = right.value;
      valid_next = right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

[rtl/slt_encoder.sv]
`default_nettype none

module slt_encoder (
  input  wire logic [slt_pkg::CAPACITY-1:0] hot,
  output logic                              any,
  output logic [slt_pkg::IDX_BITS-1:0]      index
);

  always_comb begin
    any   = |hot;
    index = '0;
    for (int i = 0; i < slt_pkg::CAPACITY; i++) begin
      if (hot[i]) begin
        index = index | slt_pkg::IDX_BITS'(i);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sorted_list_table_unit.sv]
// Sorted list of up to 64 signed 32-bit values held in a row of cells, one
// entry per cell, head at cell 0. Every cell compares its entry with the
// command value at once and trades entries with its neighbors, so insert,
// delete at a position, find and clear all act on every cell at once: one
// command is taken per clock as long as the result register is free or
// being read. Equal values sit newest first; find reports the first
// match. Each command gives exactly one result with a status, a position
// and the entry count after the command.

`default_nettype none

module sorted_list_table_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // value[31:0], position[37:32], zero padding
  input  wire logic [slt_pkg::S_DATA_BITS-1:0]    s_tdata,
  // command[1:0]
  input  wire logic [slt_pkg::CMD_BITS-1:0]       s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // status[2:0], found_position[8:3], entry_count[15:9]
  output logic [slt_pkg::M_DATA_BITS-1:0]         m_tdata
);

  localparam int CAP = slt_pkg::CAPACITY;
  localparam int IW  = slt_pkg::IDX_BITS;
  localparam int CW  = slt_pkg::COUNT_BITS;
  localparam int VW  = slt_pkg::VALUE_BITS;

  logic                        accept;
  slt_pkg::command_t           command;
  logic [VW-1:0]               value;
  logic [IW-1:0]               position;

  logic [CW-1:0]               held_count;
  logic [CW-1:0]               held_count_next;

  slt_pkg::cell_ctrl_t         ctrl;
  slt_pkg::cell_link_t         links [CAP];
  slt_pkg::cell_hit_t          hits  [CAP];
  slt_pkg::cell_link_t         edge_left;
  slt_pkg::cell_link_t         edge_right;
  logic [CAP-1:0]              first_cond;
  logic [CAP-1:0]              first_eq;
  logic                        any_cond;
  logic                        any_eq;
  logic [IW-1:0]               cond_index;
  logic [IW-1:0]               eq_index;

  slt_pkg::status_t            status_next;
  logic [IW-1:0]               found_next;
  logic                        insert_ok;
  logic                        delete_ok;

  slt_pkg::status_t            status;
  logic [IW-1:0]               found_position;
  logic [CW-1:0]               entry_count;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign command  = slt_pkg::command_t'(s_tuser);
  assign value    = s_tdata[VW-1:0];
  assign position = s_tdata[VW+IW-1:VW];

  always_comb begin
    edge_left  = '0;
    edge_right = '0;
  end

  always_comb begin
    ctrl.do_insert = accept && insert_ok;
    ctrl.do_delete = accept && delete_ok;
    ctrl.do_clear  = accept && (command == slt_pkg::CMD_CLEAR);
    ctrl.value     = value;
    ctrl.position  = position;
  end

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    slt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .cell_index(IW'(g)),
      .left      ((g == 0) ? edge_left : links[(g == 0) ? 0 : g - 1]),
      .right     ((g == CAP - 1) ? edge_right : links[(g == CAP - 1) ? g : g + 1]),
      .link      (links[g]),
      .hit       (hits[g])
    );
    assign first_cond[g] = hits[g].first_cond;
    assign first_eq[g]   = hits[g].first_eq;
  end

  slt_encoder u_cond_enc (
    .hot  (first_cond),
    .any  (any_cond),
    .index(cond_index)
  );

  slt_encoder u_eq_enc (
    .hot  (first_eq),
    .any  (any_eq),
    .index(eq_index)
  );

  always_comb begin
    insert_ok       = 1'b0;
    delete_ok       = 1'b0;
    status_next     = slt_pkg::ST_OK;
    found_next      = '0;
    held_count_next = held_count;
    unique case (command)
      slt_pkg::CMD_INSERT: begin
        if (held_count == CW'(CAP) || !any_cond) begin
          status_next = slt_pkg::ST_FULL;
        end else begin
          insert_ok       = 1'b1;
          found_next      = cond_index;
          held_count_next = held_count + CW'(1);
        end
      end
      slt_pkg::CMD_DELETE: begin
        if (held_count == '0) begin
          status_next = slt_pkg::ST_EMPTY;
        end else if (CW'(position) >= held_count) begin
          status_next = slt_pkg::ST_RANGE;
        end else begin
          delete_ok       = 1'b1;
          held_count_next = held_count - CW'(1);
        end
      end
      slt_pkg::CMD_FIND: begin
        if (held_count == '0) begin
          status_next = slt_pkg::ST_EMPTY;
        end else if (any_eq) begin
          found_next = eq_index;
        end else begin
          status_next = slt_pkg::ST_MISSING;
        end
      end
      slt_pkg::CMD_CLEAR: begin
        held_count_next = '0;
      end
      default: begin
        status_next = slt_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        held_count <= held_count_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status         <= status_next;
      found_position <= found_next;
      entry_count    <= held_count_next;
    end
  end

  assign m_tdata = slt_pkg::M_DATA_BITS'({entry_count, found_position, status});

endmodule

`default_nettype wire
